[hw/rtl/tmsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_pkg
// Types, field codes and constants shared by the tracker module stream parser.
// ----------------------------------------------------------------------------
package tmsp_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_SUBSONG  = 3'd1,
      PH_SEQUENCE = 3'd2,
      PH_TRACK    = 3'd3,
      PH_INSTR    = 3'd4,
      PH_PLAYLIST = 3'd5,
      PH_DONE     = 3'd6
   } phase_type;

   // Result status codes.
   localparam logic [1:0] ST_FIELD     = 2'd0;
   localparam logic [1:0] ST_COMPLETE  = 2'd1;
   localparam logic [1:0] ST_BAD_ID    = 2'd2;
   localparam logic [1:0] ST_TRUNCATED = 2'd3;

   // Field codes, in file layout order.
   localparam logic [5:0] FC_FORMAT        = 6'd0;
   localparam logic [5:0] FC_NAME_OFFSET   = 6'd1;
   localparam logic [5:0] FC_TRACK0        = 6'd2;
   localparam logic [5:0] FC_SONG_LEN      = 6'd3;
   localparam logic [5:0] FC_RESTART       = 6'd4;
   localparam logic [5:0] FC_TRACK_LEN     = 6'd5;
   localparam logic [5:0] FC_HIGH_TRACK    = 6'd6;
   localparam logic [5:0] FC_INSTR_COUNT   = 6'd7;
   localparam logic [5:0] FC_SUBSONG_COUNT = 6'd8;
   localparam logic [5:0] FC_SUBSONG_START = 6'd9;
   localparam logic [5:0] FC_SEQ_TRACK     = 6'd10;
   localparam logic [5:0] FC_SEQ_TRANSPOSE = 6'd11;
   localparam logic [5:0] FC_NOTE          = 6'd12;
   localparam logic [5:0] FC_INSTRUMENT    = 6'd13;
   localparam logic [5:0] FC_COMMAND       = 6'd14;
   localparam logic [5:0] FC_CMD_PARAM     = 6'd15;
   localparam logic [5:0] FC_MASTER_VOL    = 6'd16;
   localparam logic [5:0] FC_FILTER_SPEED  = 6'd17;
   localparam logic [5:0] FC_WAVE_LEN      = 6'd18;
   localparam logic [5:0] FC_ATTACK_LEN    = 6'd19;
   localparam logic [5:0] FC_FILTER_LOW    = 6'd26;
   localparam logic [5:0] FC_VIB_DELAY     = 6'd27;
   localparam logic [5:0] FC_HARD_CUT      = 6'd28;
   localparam logic [5:0] FC_RELEASE_CUT   = 6'd29;
   localparam logic [5:0] FC_VIB_DEPTH     = 6'd30;
   localparam logic [5:0] FC_VIB_SPEED     = 6'd31;
   localparam logic [5:0] FC_FILTER_HIGH   = 6'd35;
   localparam logic [5:0] FC_PLIST_SPEED   = 6'd36;
   localparam logic [5:0] FC_PLIST_LEN     = 6'd37;
   localparam logic [5:0] FC_FX2_CMD       = 6'd38;
   localparam logic [5:0] FC_FX1_CMD       = 6'd39;
   localparam logic [5:0] FC_WAVEFORM      = 6'd40;
   localparam logic [5:0] FC_FIXED_NOTE    = 6'd41;
   localparam logic [5:0] FC_NOTE_DATA     = 6'd42;
   localparam logic [5:0] FC_FX1_DATA      = 6'd43;
   localparam logic [5:0] FC_FX2_DATA      = 6'd44;

   // Identifier and format version bytes.
   localparam logic [7:0] ID_T        = 8'h54;
   localparam logic [7:0] ID_H        = 8'h48;
   localparam logic [7:0] ID_X        = 8'h58;
   localparam logic [7:0] FMT_VERSION = 8'h01;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  code;
      logic [11:0] rec;
      logic [7:0]  sub;
      logic [15:0] value;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [COUNT_W-1:0]           count;
   } bundle_type;

   typedef struct packed {
      phase_type   phase;
      logic [4:0]  byte_idx;
      logic [13:0] rec;
      logic [7:0]  entry;
      logic [11:0] positions;
      logic [7:0]  steps;
      logic [7:0]  highest;
      logic [7:0]  instr_total;
      logic [7:0]  subsong_total;
      logic        skip_zero;
      logic [7:0]  held;
      logic [7:0]  left;
      logic        id_ok;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:         PH_HEADER,
      byte_idx:      5'd0,
      rec:           14'd0,
      entry:         8'd0,
      positions:     12'd0,
      steps:         8'd0,
      highest:       8'd0,
      instr_total:   8'd0,
      subsong_total: 8'd0,
      skip_zero:     1'b0,
      held:          8'd0,
      left:          8'd0,
      id_ok:         1'b0
   };

endpackage

[hw/rtl/tmsp_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_decode
// Combinational byte decoder: from the parser state and one file byte it
// forms the next state and the set of results that the byte produces.
// ----------------------------------------------------------------------------
module tmsp_decode
   import tmsp_pkg::*;
(
   input  parse_state_type cur,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output parse_state_type nxt,
   output bundle_type      bundle
);

   logic [5:0]         fcode [3];
   logic [15:0]        fval  [3];
   logic [1:0]         nf;
   logic               bad_id;
   logic               do_settle;
   logic               match;
   logic               done_now;
   logic [8:0]         entry_inc;
   logic [11:0]        f_rec;
   logic [7:0]         f_sub;
   logic [COUNT_W-1:0] n;
   parse_state_type    step;

   // Record and sub-index of every field come from the state before the byte.
   always_comb begin
      f_rec = (cur.phase == PH_HEADER) ? 12'd0 : cur.rec[11:0];
      if (cur.phase == PH_SEQUENCE) begin
         f_sub = {5'd0, cur.byte_idx[3:1]};
      end else if (cur.phase == PH_TRACK || cur.phase == PH_PLAYLIST) begin
         f_sub = cur.entry;
      end else begin
         f_sub = 8'd0;
      end
   end

   always_comb begin
      step      = cur;
      nf        = 2'd0;
      bad_id    = 1'b0;
      do_settle = 1'b0;
      match     = 1'b0;
      entry_inc = {1'b0, cur.entry} + 9'd1;
      for (int i = 0; i < 3; i++) begin
         fcode[i] = FC_FORMAT;
         fval[i]  = 16'd0;
      end

      case (cur.phase)
         PH_HEADER: begin
            step.byte_idx = cur.byte_idx + 5'd1;
            case (cur.byte_idx)
               5'd0: step.id_ok = (data_byte == ID_T);
               5'd1: step.id_ok = cur.id_ok && (data_byte == ID_H);
               5'd2: begin
                  match       = cur.id_ok && (data_byte == ID_X);
                  step.id_ok  = match;
                  bad_id      = !match;
               end
               5'd3: begin
                  fcode[0] = FC_FORMAT;
                  fval[0]  = {15'd0, cur.id_ok && (data_byte == FMT_VERSION)};
                  nf       = 2'd1;
               end
               5'd4: step.held = data_byte;
               5'd5: begin
                  fcode[0] = FC_NAME_OFFSET;
                  fval[0]  = {cur.held, data_byte};
                  nf       = 2'd1;
               end
               5'd6: begin
                  step.held      = data_byte;
                  step.skip_zero = data_byte[7];
                  fcode[0]       = FC_TRACK0;
                  fval[0]        = {15'd0, data_byte[7]};
                  nf             = 2'd1;
               end
               5'd7: begin
                  step.positions = {cur.held[3:0], data_byte};
                  fcode[0]       = FC_SONG_LEN;
                  fval[0]        = {4'd0, cur.held[3:0], data_byte};
                  nf             = 2'd1;
               end
               5'd8: step.held = data_byte;
               5'd9: begin
                  fcode[0] = FC_RESTART;
                  fval[0]  = {cur.held, data_byte};
                  nf       = 2'd1;
               end
               5'd10: begin
                  step.steps = data_byte;
                  fcode[0]   = FC_TRACK_LEN;
                  fval[0]    = {8'd0, data_byte};
                  nf         = 2'd1;
               end
               5'd11: begin
                  step.highest = data_byte;
                  fcode[0]     = FC_HIGH_TRACK;
                  fval[0]      = {8'd0, data_byte};
                  nf           = 2'd1;
               end
               5'd12: begin
                  step.instr_total = data_byte;
                  fcode[0]         = FC_INSTR_COUNT;
                  fval[0]          = {8'd0, data_byte};
                  nf               = 2'd1;
               end
               default: begin
                  step.subsong_total = data_byte;
                  fcode[0]           = FC_SUBSONG_COUNT;
                  fval[0]            = {8'd0, data_byte};
                  nf                 = 2'd1;
                  step.phase         = PH_SUBSONG;
                  step.rec           = 14'd0;
                  step.byte_idx      = 5'd0;
                  do_settle          = 1'b1;
               end
            endcase
         end

         PH_SUBSONG: begin
            if (cur.byte_idx == 5'd0) begin
               step.held     = data_byte;
               step.byte_idx = 5'd1;
            end else begin
               fcode[0]      = FC_SUBSONG_START;
               fval[0]       = {cur.held, data_byte};
               nf            = 2'd1;
               step.rec      = cur.rec + 14'd1;
               step.byte_idx = 5'd0;
               do_settle     = 1'b1;
            end
         end

         PH_SEQUENCE: begin
            fcode[0] = cur.byte_idx[0] ? FC_SEQ_TRANSPOSE : FC_SEQ_TRACK;
            fval[0]  = {8'd0, data_byte};
            nf       = 2'd1;
            if (cur.byte_idx >= 5'd7) begin
               step.byte_idx = 5'd0;
               step.rec      = cur.rec + 14'd1;
               do_settle     = 1'b1;
            end else begin
               step.byte_idx = cur.byte_idx + 5'd1;
            end
         end

         PH_TRACK: begin
            if (cur.byte_idx == 5'd0) begin
               step.held     = data_byte;
               fcode[0]      = FC_NOTE;
               fval[0]       = {10'd0, data_byte[7:2]};
               nf            = 2'd1;
               step.byte_idx = 5'd1;
            end else if (cur.byte_idx == 5'd1) begin
               fcode[0]      = FC_INSTRUMENT;
               fval[0]       = {10'd0, cur.held[1:0], data_byte[7:4]};
               fcode[1]      = FC_COMMAND;
               fval[1]       = {12'd0, data_byte[3:0]};
               nf            = 2'd2;
               step.byte_idx = 5'd2;
            end else begin
               fcode[0]      = FC_CMD_PARAM;
               fval[0]       = {8'd0, data_byte};
               nf            = 2'd1;
               step.byte_idx = 5'd0;
               if (entry_inc >= {1'b0, cur.steps}) begin
                  step.entry = 8'd0;
                  step.rec   = cur.rec + 14'd1;
               end else begin
                  step.entry = entry_inc[7:0];
               end
               do_settle = 1'b1;
            end
         end

         PH_INSTR: begin
            step.byte_idx = cur.byte_idx + 5'd1;
            if (cur.byte_idx == 5'd0) begin
               fcode[0] = FC_MASTER_VOL;
               fval[0]  = {8'd0, data_byte};
               nf       = 2'd1;
            end else if (cur.byte_idx == 5'd1) begin
               fcode[0] = FC_FILTER_SPEED;
               fval[0]  = {8'd0, data_byte[7:3], 3'd0};
               fcode[1] = FC_WAVE_LEN;
               fval[1]  = {13'd0, data_byte[2:0]};
               nf       = 2'd2;
            end else if (cur.byte_idx <= 5'd8) begin
               // Envelope bytes map one to one onto consecutive codes.
               fcode[0] = FC_ATTACK_LEN + {1'b0, cur.byte_idx} - 6'd2;
               fval[0]  = {8'd0, data_byte};
               nf       = 2'd1;
            end else if (cur.byte_idx == 5'd12) begin
               fcode[0] = FC_FILTER_LOW;
               fval[0]  = {9'd0, data_byte[6:0]};
               nf       = 2'd1;
            end else if (cur.byte_idx == 5'd13) begin
               fcode[0] = FC_VIB_DELAY;
               fval[0]  = {8'd0, data_byte};
               nf       = 2'd1;
            end else if (cur.byte_idx == 5'd14) begin
               fcode[0] = FC_HARD_CUT;
               fval[0]  = {13'd0, data_byte[6:4]};
               fcode[1] = FC_RELEASE_CUT;
               fval[1]  = {15'd0, data_byte[7]};
               fcode[2] = FC_VIB_DEPTH;
               fval[2]  = {12'd0, data_byte[3:0]};
               nf       = 2'd3;
            end else if (cur.byte_idx >= 5'd15 && cur.byte_idx <= 5'd18) begin
               fcode[0] = FC_VIB_SPEED + {1'b0, cur.byte_idx} - 6'd15;
               fval[0]  = {8'd0, data_byte};
               nf       = 2'd1;
            end else if (cur.byte_idx == 5'd19) begin
               fcode[0] = FC_FILTER_HIGH;
               fval[0]  = {10'd0, data_byte[5:0]};
               nf       = 2'd1;
            end else if (cur.byte_idx == 5'd20) begin
               fcode[0] = FC_PLIST_SPEED;
               fval[0]  = {8'd0, data_byte};
               nf       = 2'd1;
            end else if (cur.byte_idx >= 5'd21) begin
               fcode[0]      = FC_PLIST_LEN;
               fval[0]       = {8'd0, data_byte};
               nf            = 2'd1;
               step.left     = data_byte;
               step.entry    = 8'd0;
               step.byte_idx = 5'd0;
               step.phase    = PH_PLAYLIST;
               do_settle     = 1'b1;
            end
         end

         PH_PLAYLIST: begin
            if (cur.byte_idx == 5'd0) begin
               step.held     = data_byte;
               fcode[0]      = FC_FX2_CMD;
               fval[0]       = {13'd0, data_byte[7:5]};
               fcode[1]      = FC_FX1_CMD;
               fval[1]       = {13'd0, data_byte[4], data_byte[3:2]};
               nf            = 2'd2;
               step.byte_idx = 5'd1;
            end else if (cur.byte_idx == 5'd1) begin
               fcode[0]      = FC_WAVEFORM;
               fval[0]       = {13'd0, cur.held[1:0], data_byte[7]};
               fcode[1]      = FC_FIXED_NOTE;
               fval[1]       = {15'd0, data_byte[6]};
               fcode[2]      = FC_NOTE_DATA;
               fval[2]       = {10'd0, data_byte[5:0]};
               nf            = 2'd3;
               step.byte_idx = 5'd2;
            end else if (cur.byte_idx == 5'd2) begin
               fcode[0]      = FC_FX1_DATA;
               fval[0]       = {8'd0, data_byte};
               nf            = 2'd1;
               step.byte_idx = 5'd3;
            end else begin
               fcode[0]      = FC_FX2_DATA;
               fval[0]       = {8'd0, data_byte};
               nf            = 2'd1;
               step.byte_idx = 5'd0;
               step.entry    = cur.entry + 8'd1;
               if (cur.left != 8'd0) begin
                  step.left = cur.left - 8'd1;
               end
               do_settle = 1'b1;
            end
         end

         default: begin
         end
      endcase

      // Skip over empty sections; each test sees the outcome of the one before.
      nxt = step;
      if (do_settle) begin
         if (nxt.phase == PH_SUBSONG && nxt.rec >= {6'd0, nxt.subsong_total}) begin
            nxt.phase    = PH_SEQUENCE;
            nxt.rec      = 14'd0;
            nxt.byte_idx = 5'd0;
         end
         if (nxt.phase == PH_SEQUENCE && nxt.rec >= {2'd0, nxt.positions}) begin
            nxt.phase    = PH_TRACK;
            nxt.rec      = {13'd0, nxt.skip_zero};
            nxt.entry    = 8'd0;
            nxt.byte_idx = 5'd0;
         end
         if (nxt.phase == PH_TRACK &&
             (nxt.steps == 8'd0 || nxt.rec > {6'd0, nxt.highest})) begin
            nxt.phase    = PH_INSTR;
            nxt.rec      = 14'd1;
            nxt.byte_idx = 5'd0;
         end
         if (nxt.phase == PH_PLAYLIST && nxt.left == 8'd0) begin
            nxt.phase    = PH_INSTR;
            nxt.rec      = nxt.rec + 14'd1;
            nxt.byte_idx = 5'd0;
         end
         if (nxt.phase == PH_INSTR && nxt.rec > {6'd0, nxt.instr_total}) begin
            nxt.phase = PH_DONE;
         end
      end

      done_now = (cur.phase != PH_DONE) && (nxt.phase == PH_DONE);

      // Assemble the results in order: fields (or a bad-ID status), then completion, then truncation.
      for (int i = 0; i < MAX_RESULTS; i++) begin
         bundle.slot[i] = '0;
      end
      n = '0;
      if (bad_id) begin
         bundle.slot[0].status = ST_BAD_ID;
         n = COUNT_W'(1);
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < nf) begin
               bundle.slot[i].status = ST_FIELD;
               bundle.slot[i].code   = fcode[i];
               bundle.slot[i].rec    = f_rec;
               bundle.slot[i].sub    = f_sub;
               bundle.slot[i].value  = fval[i];
            end
         end
         n = COUNT_W'(nf);
      end
      if (done_now && n < COUNT_W'(MAX_RESULTS)) begin
         bundle.slot[n[1:0]].status = ST_COMPLETE;
         n = n + COUNT_W'(1);
      end
      if (last_byte && nxt.phase != PH_DONE && n < COUNT_W'(MAX_RESULTS)) begin
         bundle.slot[n[1:0]].status = ST_TRUNCATED;
         n = n + COUNT_W'(1);
      end
      bundle.count = n;

      // The end of a file always brings the parser back to its start.
      if (last_byte) begin
         nxt = STATE_RESET;
      end
   end

endmodule

[hw/rtl/tmsp_result_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_result_queue
// Result register: holds the results of one byte and hands them out one per
// cycle on the response channel while it is ready, oldest first.
// ----------------------------------------------------------------------------
module tmsp_result_queue
   import tmsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       free,
   output logic       rsp_valid,
   output logic       rsp_last,
   output result_type rsp_item,
   input  logic       rsp_ready
);

   result_type [MAX_RESULTS-1:0] slot_ff;
   result_type [MAX_RESULTS-1:0] slot_in;
   logic [COUNT_W-1:0]           count_ff;
   logic [COUNT_W-1:0]           count_in;
   logic                         take;

   assign rsp_valid = (count_ff != '0);
   assign rsp_last  = (count_ff == COUNT_W'(1));
   assign rsp_item  = slot_ff[0];
   assign take      = rsp_valid && rsp_ready;
   // A new set may come in as the last pending result leaves.
   assign free      = (count_ff == '0) || (rsp_last && rsp_ready);

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (take) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
         count_in = count_ff - COUNT_W'(1);
      end
      if (load) begin
         slot_in  = bundle.slot;
         count_in = bundle.count;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_RESULTS))
      else $error("result count beyond capacity");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("results loaded over pending results");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (count_ff == $past(count_ff)))
      else $error("pending results changed during a stall");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      (load && bundle.count != '0) |=> rsp_valid)
      else $error("loaded results not presented");

endmodule

[hw/rtl/tracker_module_stream_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_module_stream_parser_unit
// Streaming parser for tracker module files: one file byte per request in,
// one decoded field or status per request out.
// ----------------------------------------------------------------------------
// Flow: an accepted byte is registered, decoded combinationally, and its results
// (0..4 of them) are loaded into the single result register once it is free;
// that register hands out one result a cycle while rsp_tready is high.
// Bytes yielding at most one result stream at one per cycle while rsp_tready holds.
// Reset: synchronous; clears the parser to the header and empties all stages.
// ----------------------------------------------------------------------------
module tracker_module_stream_parser_unit
   import tmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [5:0] field_code, [17:6] record_number,
                                    // [25:18] sub_number, [41:26] field_value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_data_ff;
   logic            in_last_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type state_next;
   bundle_type      bundle;
   logic            free;
   logic            load;
   logic            req_accept;
   result_type      rsp_item;

   assign load       = in_valid_ff && free;
   assign req_tready = !in_valid_ff || load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      state_in = load ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   tmsp_decode u_decode (
      .cur       (state_ff),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .nxt       (state_next),
      .bundle    (bundle)
   );

   tmsp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .free      (free),
      .rsp_valid (rsp_tvalid),
      .rsp_last  (rsp_tlast),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {6'd0, rsp_item.value, rsp_item.sub, rsp_item.rec, rsp_item.code};
   assign rsp_tuser = rsp_item.status;

endmodule
